// File: design/potts_metropolis_site_update_unit_macros.svh
// Assertion macros shared by the Potts site update unit.
// Each macro expects clk and rst in scope; no other dependencies.
`ifndef POTTS_METROPOLIS_SITE_UPDATE_UNIT_MACROS_SVH
`define POTTS_METROPOLIS_SITE_UPDATE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PMSU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PMSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pmsu_pkg.sv
// Shared types and constants for the Potts site update unit.
// No dependencies.
`timescale 1ns / 1ps

package pmsu_pkg;

  localparam int unsigned SPIN_W      = 3;
  localparam int unsigned SPIN_STATES = 5;
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned COORD_RANGE = 64;
  localparam int unsigned LEVEL_W     = 16;
  localparam int unsigned NUM_LEVELS  = 4;
  localparam int unsigned REG_IDX_W   = 2;
  localparam int unsigned CHANGE_W    = 4;
  localparam int unsigned MATCH_W     = 3;

  // action codes; the two unused codes behave as a read
  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;

  // which lattice site the read port looks at
  typedef enum logic [2:0] {
    SEL_CENTER,
    SEL_DOWN,
    SEL_RIGHT,
    SEL_UP,
    SEL_LEFT
  } site_sel_t;

  // memory request from the sequencer to the address unit and lattice RAM
  typedef struct packed {
    logic      load;
    logic      wr_en;
    site_sel_t sel;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_FETCH,
    ST_HOLD,
    ST_NB0,
    ST_NB1,
    ST_NB2,
    ST_NB3,
    ST_TALLY,
    ST_DECIDE
  } ctrl_state_t;

  function automatic logic spin_valid(input logic [SPIN_W-1:0] s);
    spin_valid = ({1'b0, s} < (SPIN_W+1)'(SPIN_STATES));
  endfunction

endpackage

// File: design/pmsu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pmsu_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/pmsu_addr.sv
// Address unit: reduces coordinates onto the periodic lattice and forms
// site and neighbor addresses. Depends on pmsu_pkg.
`timescale 1ns / 1ps

module pmsu_addr
  import pmsu_pkg::*;
#(
  parameter int unsigned LATTICE_SIDE = 64
) (
  input  logic                                        clk,
  input  mem_req_t                                    req,
  input  logic [COORD_W-1:0]                          site_x,
  input  logic [COORD_W-1:0]                          site_y,
  output logic [$clog2(LATTICE_SIDE*LATTICE_SIDE)-1:0] rd_addr,
  output logic [$clog2(LATTICE_SIDE*LATTICE_SIDE)-1:0] wr_addr
);

  localparam int unsigned CW = $clog2(LATTICE_SIDE);
  localparam int unsigned AW = $clog2(LATTICE_SIDE * LATTICE_SIDE);
  localparam logic [CW-1:0] LAST = CW'(LATTICE_SIDE - 1);

  // constant table: coordinate modulo the lattice side
  logic [CW-1:0] mod_tab [COORD_RANGE];

  for (genvar i = 0; i < COORD_RANGE; i++) begin : g_mod
    localparam int unsigned RED = i % LATTICE_SIDE;
    assign mod_tab[i] = CW'(RED);
  end

  logic [CW-1:0] xr;
  logic [CW-1:0] yr;
  logic [CW-1:0] xs;
  logic [CW-1:0] ys;
  logic [CW-1:0] x_inc;
  logic [CW-1:0] x_dec;
  logic [CW-1:0] y_inc;
  logic [CW-1:0] y_dec;

  // capture reduced site coordinates with the word
  always_ff @(posedge clk) begin
    if (req.load) begin
      xr <= mod_tab[site_x];
      yr <= mod_tab[site_y];
    end
  end

  // periodic neighbors
  always_comb begin
    x_inc = (xr == LAST) ? '0 : xr + 1'b1;
    x_dec = (xr == '0) ? LAST : xr - 1'b1;
    y_inc = (yr == LAST) ? '0 : yr + 1'b1;
    y_dec = (yr == '0) ? LAST : yr - 1'b1;
  end

  // read coordinate select
  always_comb begin
    xs = xr;
    ys = yr;
    case (req.sel)
      SEL_CENTER: begin
        xs = xr;
        ys = yr;
      end
      SEL_DOWN:  xs = x_inc;
      SEL_RIGHT: ys = y_inc;
      SEL_UP:    xs = x_dec;
      SEL_LEFT:  ys = y_dec;
      default: begin
        xs = xr;
        ys = yr;
      end
    endcase
  end

  // row-major address: row times side plus column
  assign rd_addr = AW'(AW'(xs) * AW'(LATTICE_SIDE) + AW'(ys));
  assign wr_addr = AW'(AW'(xr) * AW'(LATTICE_SIDE) + AW'(yr));

endmodule

// File: design/pmsu_ctrl.sv
// Sequencer and decision logic: serves writes and reads; for an update, walks
// the site and its four neighbors through the lattice RAM, tallies matches,
// decides, writes back if accepted. Depends on pmsu_pkg and the macro header.
`timescale 1ns / 1ps
`include "potts_metropolis_site_update_unit_macros.svh"

module pmsu_ctrl
  import pmsu_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [1:0]                          action,
  input  logic [SPIN_W-1:0]                   spin_in,
  input  logic [LEVEL_W-1:0]                  random_draw,
  input  logic [NUM_LEVELS-1:0][LEVEL_W-1:0]  levels,
  input  logic [SPIN_W-1:0]                   rd_data,
  output logic                                busy,
  output mem_req_t                            req,
  output logic [SPIN_W-1:0]                   wr_data,
  output logic                                done,
  output logic [SPIN_W-1:0]                   spin_out,
  output logic                                accepted,
  output logic signed [CHANGE_W-1:0]          match_change
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  logic [1:0]          action_r;
  logic [SPIN_W-1:0]   spin_r;
  logic [LEVEL_W-1:0]  draw_r;
  logic [SPIN_W-1:0]   old_spin;
  logic [MATCH_W-1:0]  old_match;
  logic [MATCH_W-1:0]  new_match;

  logic                       count_en;
  logic signed [CHANGE_W-1:0] change;
  logic [REG_IDX_W-1:0]       level_idx;
  logic                       accept_now;

  logic                       res_valid;
  logic [SPIN_W-1:0]          res_spin;
  logic                       res_acc;
  logic signed [CHANGE_W-1:0] res_change;

  assign busy    = (state != ST_IDLE);
  assign wr_data = spin_r;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // acceptance decision from the tallies
  always_comb begin
    change     = signed'({1'b0, old_match}) - signed'({1'b0, new_match});
    level_idx  = REG_IDX_W'(change - CHANGE_W'(1));
    accept_now = change[CHANGE_W-1] || (change == '0) || (draw_r < levels[level_idx]);
  end

  // next state, memory requests and result word
  always_comb begin
    state_next = state;
    req.load   = 1'b0;
    req.wr_en  = 1'b0;
    req.sel    = SEL_CENTER;
    count_en   = 1'b0;
    res_valid  = 1'b0;
    res_spin   = spin_r;
    res_acc    = 1'b0;
    res_change = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          req.load   = 1'b1;
          state_next = (action == ACT_WRITE && spin_valid(spin_in)) ? ST_WRITE : ST_FETCH;
        end
      end
      ST_WRITE: begin
        req.wr_en  = 1'b1;
        res_valid  = 1'b1;
        res_acc    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_FETCH: begin
        req.sel    = SEL_CENTER;
        state_next = (action_r == ACT_UPDATE && spin_valid(spin_r)) ? ST_NB0 : ST_HOLD;
      end
      ST_HOLD: begin
        res_valid  = 1'b1;
        res_spin   = rd_data;
        state_next = ST_IDLE;
      end
      ST_NB0: begin
        req.sel    = SEL_DOWN;
        state_next = ST_NB1;
      end
      ST_NB1: begin
        req.sel    = SEL_RIGHT;
        count_en   = 1'b1;
        state_next = ST_NB2;
      end
      ST_NB2: begin
        req.sel    = SEL_UP;
        count_en   = 1'b1;
        state_next = ST_NB3;
      end
      ST_NB3: begin
        req.sel    = SEL_LEFT;
        count_en   = 1'b1;
        state_next = ST_TALLY;
      end
      ST_TALLY: begin
        count_en   = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        req.wr_en  = accept_now;
        res_valid  = 1'b1;
        res_spin   = accept_now ? spin_r : old_spin;
        res_acc    = accept_now;
        res_change = change;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // item capture, old spin and neighbor tallies
  always_ff @(posedge clk) begin
    if (req.load) begin
      action_r  <= action;
      spin_r    <= spin_in;
      draw_r    <= random_draw;
      old_match <= '0;
      new_match <= '0;
    end else if (count_en) begin
      old_match <= old_match + MATCH_W'(rd_data == old_spin);
      new_match <= new_match + MATCH_W'(rd_data == spin_r);
    end
    if (state == ST_NB0) begin
      old_spin <= rd_data;
    end
  end

  // result word strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      spin_out     <= res_spin;
      accepted     <= res_acc;
      match_change <= res_change;
    end
  end

  `PMSU_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted word did not start work")
  `PMSU_ASSERT_SAME(a_done_when_idle, done, !busy, "result strobe while still busy")
  `PMSU_ASSERT_SAME(a_write_at_end, req.wr_en, state == ST_WRITE || state == ST_DECIDE,
                    "lattice written outside a final step")
  `PMSU_ASSERT_SAME(a_reject_positive, done && !accepted, !match_change[CHANGE_W-1],
                    "rejected word reports a negative change")

endmodule

// File: design/potts_metropolis_site_update_unit.sv
// Top level of the Potts Metropolis site update unit: configuration
// thresholds, address unit, sequencer and lattice RAM. Depends on pmsu_pkg.
`timescale 1ns / 1ps

// Start a word by raising start while busy is low; no new word is taken
// while busy is high. An update fetches the site and its four neighbors
// one after the other through the single read port of the lattice RAM.
// The result word is shown on spin_out, accepted and match_change for
// exactly one cycle, marked by done, in the cycle busy falls; the receiver
// cannot stall it. Lattice contents are undefined after reset until each
// site is written. Threshold registers are written through cfg_write,
// cfg_index, cfg_data; they must be written only while the unit is idle,
// which the unit itself does not enforce.
module potts_metropolis_site_update_unit
  import pmsu_pkg::*;
#(
  parameter int unsigned LATTICE_SIDE = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic [COORD_W-1:0]          site_x,
  input  logic [COORD_W-1:0]          site_y,
  input  logic [SPIN_W-1:0]           spin_in,
  input  logic [LEVEL_W-1:0]          random_draw,
  output logic                        done,
  output logic [SPIN_W-1:0]           spin_out,
  output logic                        accepted,
  output logic signed [CHANGE_W-1:0]  match_change,
  input  logic                        cfg_write,
  input  logic [REG_IDX_W-1:0]        cfg_index,
  input  logic [LEVEL_W-1:0]          cfg_data
);

  localparam int unsigned DEPTH = LATTICE_SIDE * LATTICE_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [NUM_LEVELS-1:0][LEVEL_W-1:0] levels;
  mem_req_t                           req;
  logic [AW-1:0]                      rd_addr;
  logic [AW-1:0]                      wr_addr;
  logic [SPIN_W-1:0]                  rd_data;
  logic [SPIN_W-1:0]                  wr_data;

  // acceptance thresholds
  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '0;
    end else if (cfg_write) begin
      levels[cfg_index] <= cfg_data;
    end
  end

  pmsu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .action       (action),
    .spin_in      (spin_in),
    .random_draw  (random_draw),
    .levels       (levels),
    .rd_data      (rd_data),
    .busy         (busy),
    .req          (req),
    .wr_data      (wr_data),
    .done         (done),
    .spin_out     (spin_out),
    .accepted     (accepted),
    .match_change (match_change)
  );

  pmsu_addr #(
    .LATTICE_SIDE (LATTICE_SIDE)
  ) u_addr (
    .clk     (clk),
    .req     (req),
    .site_x  (site_x),
    .site_y  (site_y),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr)
  );

  pmsu_ram #(
    .WIDTH (SPIN_W),
    .DEPTH (DEPTH)
  ) u_lattice (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: tb/potts_metropolis_site_update_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for potts_metropolis_site_update_unit: directed lattice
// loads, match-change cases and random Metropolis traffic with sender gaps.
// Depends on pmsu_pkg and the unit's RTL.

module potts_metropolis_site_update_unit_test;
  import pmsu_pkg::*;

  localparam int unsigned SITES       = COORD_RANGE * COORD_RANGE;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_WORDS = 490;

  // read codes; the spare code behaves as a read
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // threshold register indexes
  localparam logic [REG_IDX_W-1:0] LVL_ONE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] LVL_TWO   = 2'd1;
  localparam logic [REG_IDX_W-1:0] LVL_THREE = 2'd2;
  localparam logic [REG_IDX_W-1:0] LVL_FOUR  = 2'd3;

  localparam logic [LEVEL_W-1:0] DRAW_MAX = '1;

  typedef struct packed {
    logic [SPIN_W-1:0]          spin;
    logic                       accepted;
    logic signed [CHANGE_W-1:0] change;
  } site_result_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic [1:0]                 action;
  logic [COORD_W-1:0]         site_x;
  logic [COORD_W-1:0]         site_y;
  logic [SPIN_W-1:0]          spin_in;
  logic [LEVEL_W-1:0]         random_draw;
  logic                       done;
  logic [SPIN_W-1:0]          spin_out;
  logic                       accepted;
  logic signed [CHANGE_W-1:0] match_change;
  logic                       cfg_write;
  logic [REG_IDX_W-1:0]       cfg_index;
  logic [LEVEL_W-1:0]         cfg_data;

  // shadow lattice, thresholds and the words still owed by the unit
  logic [SPIN_W-1:0]  lattice_spins [SITES];
  bit                 site_loaded   [SITES];
  logic [LEVEL_W-1:0] level_shadow  [NUM_LEVELS];
  site_result_t       owed_results [$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned words_sent;
  int unsigned update_words;
  int unsigned update_taken;
  int unsigned write_words;
  int unsigned read_words;
  bit          change_seen [9];

  potts_metropolis_site_update_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .site_x       (site_x),
    .site_y       (site_y),
    .spin_in      (spin_in),
    .random_draw  (random_draw),
    .done         (done),
    .spin_out     (spin_out),
    .accepted     (accepted),
    .match_change (match_change),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d words owed", cycle_count,
             owed_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned site_addr(input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
    return 32'({x, y});
  endfunction

  // Metropolis step on the shadow lattice; returns the word the unit owes
  function automatic site_result_t predict_site_word(
      input logic [1:0] act, input logic [COORD_W-1:0] x,
      input logic [COORD_W-1:0] y, input logic [SPIN_W-1:0] spin,
      input logic [LEVEL_W-1:0] draw);
    site_result_t      r;
    logic [SPIN_W-1:0] nb [4];
    logic [SPIN_W-1:0] old_spin;
    int                old_hits;
    int                new_hits;
    int                delta;
    int unsigned       here;
    here       = site_addr(x, y);
    r.accepted = 1'b0;
    delta      = 0;
    if (act == ACT_UPDATE && spin_valid(spin)) begin
      old_spin = lattice_spins[here];
      nb[0]    = lattice_spins[site_addr(x + 1'b1, y)];
      nb[1]    = lattice_spins[site_addr(x, y + 1'b1)];
      nb[2]    = lattice_spins[site_addr(x - 1'b1, y)];
      nb[3]    = lattice_spins[site_addr(x, y - 1'b1)];
      old_hits = 0;
      new_hits = 0;
      for (int i = 0; i < 4; i++) begin
        if (nb[i] == old_spin) old_hits++;
        if (nb[i] == spin) new_hits++;
      end
      delta = old_hits - new_hits;
      // losses pay against the threshold for their size
      if (delta <= 0) r.accepted = 1'b1;
      else if (draw < level_shadow[delta-1]) r.accepted = 1'b1;
      if (r.accepted) lattice_spins[here] = spin;
    end else if (act == ACT_WRITE && spin_valid(spin)) begin
      lattice_spins[here] = spin;
      site_loaded[here]   = 1'b1;
      r.accepted          = 1'b1;
    end
    r.spin   = lattice_spins[here];
    r.change = CHANGE_W'(delta);
    return r;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
  endfunction

  // check each result word against the oldest owed word
  always @(posedge clk) begin
    site_result_t want;
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        note_mismatch($sformatf("word with none owed: spin_out=%0d accepted=%0d change=%0d",
                                spin_out, accepted, match_change));
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        if (spin_out !== want.spin || accepted !== want.accepted ||
            match_change !== want.change) begin
          note_mismatch($sformatf(
            "spin_out exp %0d got %0d, accepted exp %0d got %0d, change exp %0d got %0d",
            want.spin, spin_out, want.accepted, accepted,
            $signed(want.change), match_change));
        end
      end
    end
  end

  // present one word, hold it until the unit takes it, then predict
  task automatic send_site_word(input logic [1:0] act, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y,
                                input logic [SPIN_W-1:0] spin,
                                input logic [LEVEL_W-1:0] draw);
    site_result_t r;
    @(negedge clk);
    start       <= 1'b1;
    action      <= act;
    site_x      <= x;
    site_y      <= y;
    spin_in     <= spin;
    random_draw <= draw;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_site_word(act, x, y, spin, draw);
    owed_results.push_back(r);
    words_sent++;
    if (act == ACT_UPDATE && spin_valid(spin)) begin
      update_words++;
      if (r.accepted) update_taken++;
      change_seen[int'(r.change) + 4] = 1'b1;
    end else if (act == ACT_WRITE) begin
      write_words++;
    end else if (act != ACT_UPDATE) begin
      read_words++;
    end
  endtask

  // random sender gap, pct chance per cycle
  task automatic sender_gap(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
      while ($urandom_range(99) < pct) @(negedge clk);
    end
  endtask

  // stop sending until every owed word has come back
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  task automatic load_level(input logic [REG_IDX_W-1:0] idx,
                            input logic [LEVEL_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    level_shadow[idx] = value;
  endtask

  // thresholds are only written with the unit idle
  task automatic load_levels(input logic [LEVEL_W-1:0] one, input logic [LEVEL_W-1:0] two,
                             input logic [LEVEL_W-1:0] three,
                             input logic [LEVEL_W-1:0] four);
    wait_for_results();
    load_level(LVL_ONE, one);
    load_level(LVL_TWO, two);
    load_level(LVL_THREE, three);
    load_level(LVL_FOUR, four);
  endtask

  // fill the corner around (0,0) so wraparound neighbors are all known
  task automatic test_lattice_load();
    send_site_word(ACT_WRITE, 6'd0, 6'd0, 3'd1, '0);
    send_site_word(ACT_WRITE, 6'd1, 6'd0, 3'd1, '0);
    send_site_word(ACT_WRITE, 6'd0, 6'd1, 3'd1, DRAW_MAX);
    send_site_word(ACT_WRITE, 6'd63, 6'd0, 3'd1, '0);
    send_site_word(ACT_WRITE, 6'd0, 6'd63, 3'd1, '0);
    send_site_word(ACT_WRITE, 6'd63, 6'd63, 3'd4, DRAW_MAX);
    // too-large value on a loaded site is dropped
    send_site_word(ACT_WRITE, 6'd63, 6'd63, 3'd7, '0);
    send_site_word(ACT_READ, 6'd0, 6'd0, 3'd7, DRAW_MAX);
    send_site_word(ACT_SPARE, 6'd63, 6'd63, 3'd0, '0);
  endtask

  // walk the center site through gains, losses and the threshold edges
  task automatic test_match_change();
    // thresholds still zero: a full loss never passes
    send_site_word(ACT_UPDATE, 6'd0, 6'd0, 3'd2, '0);
    // proposal equal to present spin: no change, accepted
    send_site_word(ACT_UPDATE, 6'd0, 6'd0, 3'd1, DRAW_MAX);
    load_levels('1, '1, '1, '1);
    // draw equal to the threshold fails, one below passes
    send_site_word(ACT_UPDATE, 6'd0, 6'd0, 3'd3, DRAW_MAX);
    send_site_word(ACT_UPDATE, 6'd0, 6'd0, 3'd3, DRAW_MAX - 1'b1);
    send_site_word(ACT_UPDATE, 6'd0, 6'd0, 3'd1, DRAW_MAX);
    send_site_word(ACT_WRITE, 6'd63, 6'd0, 3'd2, '0);
    send_site_word(ACT_UPDATE, 6'd0, 6'd0, 3'd2, '0);
    send_site_word(ACT_UPDATE, 6'd0, 6'd0, 3'd4, DRAW_MAX);
    send_site_word(ACT_UPDATE, 6'd0, 6'd0, 3'd1, '0);
  endtask

  // proposals and writes outside the spin range leave the site alone
  task automatic test_rejected_proposal();
    send_site_word(ACT_UPDATE, 6'd0, 6'd0, 3'd5, '0);
    send_site_word(ACT_UPDATE, 6'd0, 6'd0, 3'd7, '0);
    send_site_word(ACT_WRITE, 6'd0, 6'd0, 3'd6, DRAW_MAX);
    send_site_word(ACT_READ, 6'd0, 6'd0, 3'd0, '0);
  endtask

  // random traffic, mostly inside an 8x8 window so neighbors get loaded
  task automatic test_random_traffic(input int unsigned pct, input int unsigned words,
                                     input logic [COORD_W-1:0] wx,
                                     input logic [COORD_W-1:0] wy);
    logic [1:0]         act;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SPIN_W-1:0]  spin;
    logic [LEVEL_W-1:0] draw;
    int unsigned        pick;
    int unsigned        counted;
    counted = 0;
    while (counted < words) begin
      if ($urandom_range(9) < 7) begin
        x = wx + COORD_W'($urandom_range(7));
        y = wy + COORD_W'($urandom_range(7));
      end else begin
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 62) act = ACT_UPDATE;
      else if (pick < 80) act = ACT_WRITE;
      else if (pick < 92) act = ACT_READ;
      else act = ACT_SPARE;
      if ($urandom_range(9) == 0) spin = SPIN_W'($urandom_range(7, SPIN_STATES));
      else spin = SPIN_W'($urandom_range(SPIN_STATES - 1));
      pick = $urandom_range(19);
      if (pick == 0) draw = '0;
      else if (pick == 1) draw = DRAW_MAX;
      else draw = LEVEL_W'($urandom);
      // never touch a site, or a neighbor of an updated site, before it is loaded
      if (act == ACT_UPDATE &&
          !(site_loaded[site_addr(x + 1'b1, y)] && site_loaded[site_addr(x, y + 1'b1)] &&
            site_loaded[site_addr(x - 1'b1, y)] && site_loaded[site_addr(x, y - 1'b1)]))
        act = ACT_WRITE;
      if (!site_loaded[site_addr(x, y)]) begin
        act = ACT_WRITE;
        if (!spin_valid(spin)) spin = SPIN_W'($urandom_range(SPIN_STATES - 1));
      end
      counted++;
      sender_gap(pct);
      send_site_word(act, x, y, spin, draw);
      // now and then let the unit drain completely
      if ($urandom_range(149) == 0) wait_for_results();
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    action      = ACT_UPDATE;
    site_x      = '0;
    site_y      = '0;
    spin_in     = '0;
    random_draw = '0;
    cfg_write   = 1'b0;
    cfg_index   = LVL_ONE;
    cfg_data    = '0;
    cycle_count = 0;
    for (int i = 0; i < SITES; i++) lattice_spins[i] = '0;
    for (int i = 0; i < NUM_LEVELS; i++) level_shadow[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_lattice_load();
    test_match_change();
    test_rejected_proposal();

    // losses never pass, no sender gaps, window across the wrap corner
    load_levels('0, '0, '0, '0);
    test_random_traffic(0, PHASE_WORDS, 6'd60, 6'd60);
    // losses almost always pass, sparse sender
    load_levels('1, '1, '1, '1);
    test_random_traffic(88, PHASE_WORDS, COORD_W'($urandom), COORD_W'($urandom));
    load_levels(LEVEL_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
                LEVEL_W'($urandom));
    test_random_traffic(26, PHASE_WORDS, COORD_W'($urandom), COORD_W'($urandom));
    // levels for J/T = 0.5
    load_levels(16'd39750, 16'd24109, 16'd14623, 16'd8869);
    test_random_traffic(0, PHASE_WORDS, 6'd60, 6'd60);

    wait_for_results();
    repeat (16) @(posedge clk);

    $display("Sent %0d words: %0d updates (%0d taken), %0d writes, %0d reads; %0d checked",
             words_sent, update_words, update_taken, write_words, read_words,
             results_checked);
    $display("Match change values hit: %0d of 9 in -4..4; %0d mismatching words",
             change_seen.sum() with (int'(item)), mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
